/* src/indexed_list_store_defines.svh */
// Assertion macros for the indexed list store checker.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed list store check failed");

// The consequent must hold after the antecedent, delayed by the macro argument n.
`define ILS_ASSERT_AFTER(lbl, n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error("indexed list store latency check failed");

`endif

/* src/ils_pkg.sv */
// Shared types and constants for the indexed list store.
// Used by the cell, the read tree, the top level and the checker.
package ils_pkg;

    localparam int CAPACITY  = 64;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP_SIZE  = 8;
    localparam int NUM_GRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int LATENCY   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_READ      = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_OVERWRITE = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_WRITE,
        MODE_INSERT,
        MODE_REMOVE
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [CMP_W-1:0]   sel;
        logic               rd;
        logic [WORD_W-1:0]  data;
    } t_ctrl;

endpackage

/* src/indexed_list_store.sv */
// Indexed list store: a chain of word cells that appends, inserts, reads, removes and
// overwrites, with insert and remove shifting every later cell at once. Each result
// is staged through r_v1, r_v2 and r_v3 to o_strobe; one request per cycle unless busy.
// The read path is the cell capture register followed by a two-level registered OR tree.
// Reset clears the length and the result pipeline; busy is high in the cycle after reset.
// Stored words are not cleared, and results cannot be held off by the receiver.
module indexed_list_store (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ils_pkg::OP_W-1:0]           i_operation,
    input  logic [ils_pkg::POS_W-1:0]          i_position,
    input  logic signed [ils_pkg::WORD_W-1:0]  i_word_in,
    output logic                               o_strobe,
    output logic signed [ils_pkg::WORD_W-1:0]  o_word_out,
    output logic [ils_pkg::COUNT_W-1:0]        o_count,
    output logic [ils_pkg::STAT_W-1:0]         o_status
);
    import ils_pkg::*;

    logic              r_busy;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  n_len;
    logic              accept;
    t_ctrl             ctrl;
    t_status           stat;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic              full;

    logic              r_v1, r_v2, r_v3;
    logic [CNT_W-1:0]  r_cnt1, r_cnt2, r_cnt3;
    t_status           r_st1, r_st2, r_st3;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_read [CAPACITY];
    logic [WORD_W-1:0] tree_word;

    assign accept  = start && !r_busy;
    assign pos_ext = CMP_W'(i_position);
    assign len_ext = CMP_W'(r_len);
    assign full    = (r_len == CNT_W'(CAPACITY));

    always_comb begin
        ctrl.mode = MODE_HOLD;
        ctrl.sel  = pos_ext;
        ctrl.rd   = 1'b0;
        ctrl.data = i_word_in;
        stat      = ST_OK;
        n_len     = r_len;
        if (accept) begin
            case (t_op'(i_operation))
                OP_APPEND: begin
                    if (full) begin
                        stat = ST_FULL;
                    end else begin
                        ctrl.mode = MODE_WRITE;
                        ctrl.sel  = len_ext;
                        n_len     = r_len + 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (pos_ext > len_ext) begin
                        stat = ST_OOB;
                    end else if (full) begin
                        stat = ST_FULL;
                    end else begin
                        ctrl.mode = MODE_INSERT;
                        n_len     = r_len + 1'b1;
                    end
                end
                OP_READ: begin
                    if (pos_ext >= len_ext) begin
                        stat = ST_OOB;
                    end else begin
                        ctrl.rd = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (pos_ext >= len_ext) begin
                        stat = ST_OOB;
                    end else begin
                        ctrl.mode = MODE_REMOVE;
                        n_len     = r_len - 1'b1;
                    end
                end
                OP_OVERWRITE: begin
                    if (pos_ext >= len_ext) begin
                        stat = ST_OOB;
                    end else begin
                        ctrl.mode = MODE_WRITE;
                    end
                end
                default: begin
                    stat = ST_OK;
                end
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [WORD_W-1:0] lower;
            logic [WORD_W-1:0] upper;
            if (k == 0) begin : g_first
                assign lower = '0;
            end else begin : g_rest
                assign lower = cell_word[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign upper = cell_word[k];
            end else begin : g_mid
                assign upper = cell_word[k+1];
            end
            ils_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(k)),
                .i_ctrl  (ctrl),
                .i_lower (lower),
                .i_upper (upper),
                .o_word  (cell_word[k]),
                .o_read  (cell_read[k])
            );
        end
    endgenerate

    ils_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_leaf (cell_read),
        .o_word (tree_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_len  <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_len  <= n_len;
            r_v1   <= accept;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt1 <= n_len;
        r_st1  <= stat;
        r_cnt2 <= r_cnt1;
        r_st2  <= r_st1;
        r_cnt3 <= r_cnt2;
        r_st3  <= r_st2;
    end

    assign busy       = r_busy;
    assign o_strobe   = r_v3;
    assign o_word_out = tree_word;
    assign o_count    = COUNT_W'(r_cnt3);
    assign o_status   = r_st3;
endmodule

/* src/ils_cell.sv */
// One storage cell of the list chain: holds one word and trades it with its neighbors.
// Depends on ils_pkg.
module ils_cell (
    input  logic                        i_clk,
    input  logic [ils_pkg::IDX_W-1:0]   i_index,
    input  ils_pkg::t_ctrl              i_ctrl,
    input  logic [ils_pkg::WORD_W-1:0]  i_lower,
    input  logic [ils_pkg::WORD_W-1:0]  i_upper,
    output logic [ils_pkg::WORD_W-1:0]  o_word,
    output logic [ils_pkg::WORD_W-1:0]  o_read
);
    import ils_pkg::*;

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_read;
    logic [WORD_W-1:0] n_read;
    logic              hit;
    logic              above;

    assign hit   = (i_ctrl.sel == CMP_W'(i_index));
    assign above = (i_ctrl.sel < CMP_W'(i_index));

    always_comb begin
        n_word = r_word;
        unique case (i_ctrl.mode)
            MODE_WRITE: begin
                if (hit) begin
                    n_word = i_ctrl.data;
                end
            end
            MODE_INSERT: begin
                if (hit) begin
                    n_word = i_ctrl.data;
                end else if (above) begin
                    n_word = i_lower;
                end
            end
            MODE_REMOVE: begin
                if (hit || above) begin
                    n_word = i_upper;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
        n_read = (i_ctrl.rd && hit) ? r_word : '0;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_read <= n_read;
    end

    assign o_word = r_word;
    assign o_read = r_read;
endmodule

/* src/ils_read_tree.sv */
// Registered two-level OR tree that collects the read word from the cells.
// Depends on ils_pkg.
module ils_read_tree (
    input  logic                        i_clk,
    input  logic [ils_pkg::WORD_W-1:0]  i_leaf [ils_pkg::CAPACITY],
    output logic [ils_pkg::WORD_W-1:0]  o_word
);
    import ils_pkg::*;

    logic [WORD_W-1:0] r_grp [NUM_GRP];
    logic [WORD_W-1:0] n_grp [NUM_GRP];
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < CAPACITY) begin
                    n_grp[g] = n_grp[g] | i_leaf[g * GRP_SIZE + j];
                end
            end
        end
        n_word = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_word = n_word | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_word <= n_word;
    end

    assign o_word = r_word;
endmodule

/* src/ils_checker.sv */
// Port-level checker for the indexed list store, bound to the top level.
// Depends on ils_pkg and indexed_list_store_defines.svh.
`include "indexed_list_store_defines.svh"

module ils_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               o_strobe,
    input  logic signed [ils_pkg::WORD_W-1:0]  o_word_out,
    input  logic [ils_pkg::COUNT_W-1:0]        o_count,
    input  logic [ils_pkg::STAT_W-1:0]         o_status
);
    import ils_pkg::*;

    `ILS_ASSERT_AFTER(a_latency, LATENCY, start && !busy, o_strobe)
    `ILS_ASSERT_SAME(a_fail_zero, o_strobe && o_status != ST_OK, o_word_out == '0)
    `ILS_ASSERT_SAME(a_full_count, o_strobe && o_status == ST_FULL, o_count == COUNT_W'(CAPACITY))
    `ILS_ASSERT_SAME(a_count_max, o_strobe, o_count <= COUNT_W'(CAPACITY))
endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
